// ===== sv/path_word_hash_macros.svh =====
// assertion macros of the path word hash controller
// expects i_clk and i_rst_n in the scope of each use
`ifndef PATH_WORD_HASH_MACROS_SVH
`define PATH_WORD_HASH_MACROS_SVH

// same-cycle implication, checked outside reset
`define PWH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("path_word_hash: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PWH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("path_word_hash: next-cycle check failed");

`endif

// ===== sv/pwh_pkg.sv =====
// shared constants and types of the path word hash
// no dependencies
package pwh_pkg;

    localparam int unsigned MAX_WORDS_DEF = 64;

    localparam logic [31:0] PAD_ONE = 32'h9BE7_4448;
    localparam logic [31:0] PAD_TWO = 32'h66F4_2C48;
    localparam logic [31:0] V_INIT  = 32'hF4FA_8928;
    localparam logic [31:0] X_INIT  = 32'h37A8_470E;
    localparam logic [31:0] Y_INIT  = 32'h7758_B42B;
    localparam logic [31:0] W_XOR   = 32'h267B_0B11;
    localparam logic [31:0] OR_A    = 32'h0204_0801;
    localparam logic [31:0] AND_C   = 32'hBFEF_7FDF;
    localparam logic [31:0] OR_B    = 32'h0080_4021;
    localparam logic [31:0] AND_D   = 32'h7DFE_FBFF;

    // word fed into a round
    typedef enum logic [1:0] {
        SRC_MSG  = 2'd0,
        SRC_PAD1 = 2'd1,
        SRC_PAD2 = 2'd2
    } t_src;

    typedef struct packed {
        logic rnd_a;   // first half: x multiply, key rotate
        logic rnd_b;   // second half: y multiply, both folds
        t_src src;
        logic emit;    // load output, restore initial state
        logic trunc;
    } t_cmd;

    typedef struct packed {
        logic word_zero;
        logic last;
    } t_sts;

endpackage

// ===== sv/pwh_if.sv =====
// request channels of the path word hash
// depends on nothing
interface pwh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last;

    modport source (output valid, output word, output last, input ready);
    modport sink (input valid, input word, input last, output ready);
endinterface

interface pwh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;
    logic        truncated;

    modport source (output valid, output hash, output truncated, input ready);
    modport sink (input valid, input hash, input truncated, output ready);
endinterface

// ===== sv/path_word_hash.sv =====
// Path word hash, top level. Input channel i_in carries one 32-bit path word
// and a last flag per request; output channel o_out carries the 32-bit hash and
// a truncated flag, one request per path.
// A zero word, or a word with last set, ends the path; a zero word is not hashed.
// Words after MAX_WORDS hashed words are dropped and set truncated.
// Sequencing: every round uses one shared 32x32 multiplier twice, so a hashed word
// holds the input through its accept cycle and the S_RY state. Finishing a path
// adds two padding rounds (S_RX, then S_RY) and the S_EMIT state, which loads
// the output register; a zero word goes straight to the padding rounds.
// The result sits in an output register; the next path's words are accepted
// while it waits. If the receiver stalls, the block holds in the load state
// at the end of the next path until the register is taken.
// Reset (synchronous, active low) restores the initial accumulators and key,
// clears the word count and drops any pending result. After each result the
// state returns to the same initial values. No clearing pass is needed.
// Depends on pwh_pkg, pwh_if, pwh_dp and pwh_ctrl.
module path_word_hash #(
    parameter int unsigned MAX_WORDS = pwh_pkg::MAX_WORDS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pwh_in_if.sink    i_in,
    pwh_out_if.source o_out
);

    pwh_pkg::t_cmd cmd;
    pwh_pkg::t_sts sts;

    pwh_ctrl #(
        .MAX_WORDS (MAX_WORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pwh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_word      (i_in.word),
        .i_last      (i_in.last),
        .o_hash      (o_out.hash),
        .o_truncated (o_out.truncated)
    );

endmodule

// ===== sv/pwh_dp.sv =====
// datapath: accumulators, rotating key, shared 32x32 multiplier, result register
// depends on pwh_pkg
module pwh_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pwh_pkg::t_cmd  i_cmd,
    output pwh_pkg::t_sts  o_sts,
    input  logic [31:0]    i_word,
    input  logic           i_last,
    output logic [31:0]    o_hash,
    output logic           o_truncated
);

    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic [31:0] r_v, n_v;
    logic [63:0] r_px, n_px;
    logic [31:0] r_b, n_b;
    logic [31:0] r_hash;
    logic        r_trunc;

    logic [31:0] m, v_rot, w, x1, y1, a, b;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [32:0] tx, ty;
    logic [31:0] fold_x, fold_y;

    assign o_sts.word_zero = (i_word == 32'd0);
    assign o_sts.last      = i_last;

    always_comb begin
        unique case (i_cmd.src)
            pwh_pkg::SRC_MSG:  m = i_word;
            pwh_pkg::SRC_PAD1: m = pwh_pkg::PAD_ONE;
            pwh_pkg::SRC_PAD2: m = pwh_pkg::PAD_TWO;
            default:           m = pwh_pkg::PAD_TWO;
        endcase
    end

    assign v_rot = {r_v[30:0], r_v[31]};
    assign w     = v_rot ^ pwh_pkg::W_XOR;
    assign x1    = r_x ^ m;
    assign y1    = r_y ^ m;
    assign a     = ((w + y1) | pwh_pkg::OR_A) & pwh_pkg::AND_C;
    assign b     = ((w + x1) | pwh_pkg::OR_B) & pwh_pkg::AND_D;

    // one multiplier, x operand in the first half, y operand in the second
    assign mul_a = i_cmd.rnd_b ? r_y : x1;
    assign mul_b = i_cmd.rnd_b ? r_b : a;
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

    // x: fold halves, end-around carry; a nonzero high half adds one more
    assign tx     = {1'b0, r_px[31:0]} + {1'b0, r_px[63:32]}
                  + {32'd0, (r_px[63:32] != 32'd0)};
    assign fold_x = tx[31:0] + {31'd0, tx[32]};

    // y: doubled high half plus its top bit, a carry out adds two
    assign ty     = {1'b0, prod[31:0]} + {1'b0, prod[62:32], 1'b0} + {32'd0, prod[63]};
    assign fold_y = ty[31:0] + {30'd0, ty[32], 1'b0};

    always_comb begin
        n_x  = r_x;
        n_y  = r_y;
        n_v  = r_v;
        n_px = r_px;
        n_b  = r_b;
        if (i_cmd.emit) begin
            n_x = pwh_pkg::X_INIT;
            n_y = pwh_pkg::Y_INIT;
            n_v = pwh_pkg::V_INIT;
        end else if (i_cmd.rnd_a) begin
            n_v  = v_rot;
            n_y  = y1;
            n_px = prod;
            n_b  = b;
        end else if (i_cmd.rnd_b) begin
            n_x = fold_x;
            n_y = fold_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= pwh_pkg::X_INIT;
            r_y <= pwh_pkg::Y_INIT;
            r_v <= pwh_pkg::V_INIT;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;
        r_b  <= n_b;
        if (i_cmd.emit) begin
            r_hash  <= r_x ^ r_y;
            r_trunc <= i_cmd.trunc;
        end
    end

    assign o_hash      = r_hash;
    assign o_truncated = r_trunc;

endmodule

// ===== sv/pwh_ctrl.sv =====
// controller: sequences message and padding rounds, word count, result valid
// depends on pwh_pkg and path_word_hash_macros.svh
`include "path_word_hash_macros.svh"

module pwh_ctrl #(
    parameter int unsigned MAX_WORDS = pwh_pkg::MAX_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pwh_pkg::t_sts  i_sts,
    output pwh_pkg::t_cmd  o_cmd
);

    localparam int unsigned CNT_W = $clog2(MAX_WORDS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RX   = 4'b0010,
        S_RY   = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    pwh_pkg::t_src     r_src, n_src;
    logic              r_end, n_end;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_over, n_over;
    logic              r_o_valid, n_o_valid;

    logic accept, room, hashable, ends, out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign room       = (r_count < CNT_W'(MAX_WORDS));
    assign hashable   = !i_sts.word_zero && room;
    assign ends       = i_sts.word_zero || i_sts.last;
    assign out_free   = !r_o_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_src       = r_src;
        n_end       = r_end;
        n_count     = r_count;
        n_over      = r_over;
        n_o_valid   = r_o_valid && !i_out_ready;
        o_cmd.rnd_a = 1'b0;
        o_cmd.rnd_b = 1'b0;
        o_cmd.src   = r_src;
        o_cmd.emit  = 1'b0;
        o_cmd.trunc = r_over;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.src = pwh_pkg::SRC_MSG;
                if (accept) begin
                    if (!i_sts.word_zero && !room) begin
                        n_over = 1'b1;
                    end
                    if (hashable) begin
                        // first half of the round runs on the accepted word
                        o_cmd.rnd_a = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                        n_src       = pwh_pkg::SRC_MSG;
                        n_end       = ends;
                        n_state     = S_RY;
                    end else if (ends) begin
                        n_src   = pwh_pkg::SRC_PAD1;
                        n_state = S_RX;
                    end
                end
            end
            S_RX: begin
                o_cmd.rnd_a = 1'b1;
                n_state     = S_RY;
            end
            S_RY: begin
                o_cmd.rnd_b = 1'b1;
                unique case (r_src)
                    pwh_pkg::SRC_MSG: begin
                        if (r_end) begin
                            n_src   = pwh_pkg::SRC_PAD1;
                            n_state = S_RX;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    pwh_pkg::SRC_PAD1: begin
                        n_src   = pwh_pkg::SRC_PAD2;
                        n_state = S_RX;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_o_valid  = 1'b1;
                    n_count    = '0;
                    n_over     = 1'b0;
                    n_end      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_src     <= pwh_pkg::SRC_MSG;
            r_end     <= 1'b0;
            r_count   <= '0;
            r_over    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_src     <= n_src;
            r_end     <= n_end;
            r_count   <= n_count;
            r_over    <= n_over;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_out_valid = r_o_valid;

    `PWH_ASSERT_NOW(a_emit_free, o_cmd.emit, !r_o_valid || i_out_ready)
    `PWH_ASSERT_NEXT(a_half_follows, o_cmd.rnd_a, r_state == S_RY)
    `PWH_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_WORDS))
    `PWH_ASSERT_NEXT(a_emit_clears, o_cmd.emit, r_count == '0 && !r_over && r_o_valid)

endmodule

// ===== tb/path_word_hash_tb.sv =====
// self-checking testbench of the path word hash: directed and random paths against a local hash model
// depends on pwh_pkg, the pwh_in_if / pwh_out_if channels and path_word_hash
module path_word_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned RESET_TICKS = 10;
    localparam int unsigned WORD_BUDGET = 1250;
    localparam int unsigned HOLD_TICKS  = 400;
    localparam int unsigned TAIL_TICKS  = 20;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        logic [31:0] hash;
        logic        truncated;
    } t_path_hash;

    typedef enum int unsigned {
        END_LAST,       // final nonzero word carries last
        END_ZERO,       // zero word closes the path
        END_ZERO_LAST   // zero word with last set
    } t_path_end;

    class t_hash_tracker;
        logic [31:0]  acc_x;
        logic [31:0]  acc_y;
        logic [31:0]  rot_v;
        int unsigned  words_hashed;
        bit           dropped_words;
        t_path_hash   pending_hashes[$];
        int unsigned  error_count;

        function new();
            error_count = 0;
            restart();
        endfunction

        function void restart();
            acc_x         = pwh_pkg::X_INIT;
            acc_y         = pwh_pkg::Y_INIT;
            rot_v         = pwh_pkg::V_INIT;
            words_hashed  = 0;
            dropped_words = 1'b0;
        endfunction

        function void mix_word(input logic [31:0] m);
            logic [31:0] w;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] nx;
            logic [31:0] ny;
            logic [63:0] p;
            logic [32:0] t;
            rot_v = {rot_v[30:0], rot_v[31]};
            w     = rot_v ^ pwh_pkg::W_XOR;
            acc_x = acc_x ^ m;
            acc_y = acc_y ^ m;
            a = ((w + acc_y) | pwh_pkg::OR_A) & pwh_pkg::AND_C;
            b = ((w + acc_x) | pwh_pkg::OR_B) & pwh_pkg::AND_D;
            // x: fold halves, add one if high half nonzero, end-around carry
            p  = {32'd0, acc_x} * {32'd0, a};
            t  = {1'b0, p[31:0]} + {1'b0, p[63:32]} + {32'd0, p[63:32] != 32'd0};
            nx = t[31:0] + {31'd0, t[32]};
            // y: doubled high half plus its top bit, carry out adds two
            p  = {32'd0, acc_y} * {32'd0, b};
            t  = {1'b0, p[31:0]} + {1'b0, p[62:32], 1'b0} + {32'd0, p[63]};
            ny = t[31:0] + (t[32] ? 32'd2 : 32'd0);
            acc_x = nx;
            acc_y = ny;
        endfunction

        function void note_word(input logic [31:0] word, input logic last);
            t_path_hash res;
            if (word != 32'd0) begin
                if (words_hashed < pwh_pkg::MAX_WORDS_DEF) begin
                    mix_word(word);
                    words_hashed++;
                end else begin
                    dropped_words = 1'b1;
                end
            end
            if (word == 32'd0 || last) begin
                mix_word(pwh_pkg::PAD_ONE);
                mix_word(pwh_pkg::PAD_TWO);
                res.hash      = acc_x ^ acc_y;
                res.truncated = dropped_words;
                pending_hashes.insert(pending_hashes.size(), res);
                restart();
            end
        endfunction

        function void check_hash(input logic [31:0] hash, input logic truncated);
            t_path_hash exp_res;
            if (pending_hashes.size() == 0) begin
                $error("unexpected hash request: hash %h truncated %b", hash, truncated);
                error_count++;
                return;
            end
            exp_res = pending_hashes.pop_front();
            if (hash !== exp_res.hash) begin
                $error("hash mismatch: expected %h actual %h", exp_res.hash, hash);
                error_count++;
            end
            if (truncated !== exp_res.truncated) begin
                $error("truncated mismatch: expected %b actual %b",
                       exp_res.truncated, truncated);
                error_count++;
            end
        endfunction

        function bit all_clear();
            if (pending_hashes.size() != 0) begin
                $error("%0d hash requests never arrived", pending_hashes.size());
                error_count++;
            end
            return error_count == 0;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pwh_in_if  in_ch();
    pwh_out_if out_ch();

    path_word_hash DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_hash_tracker hashes = new();

    int unsigned cycle_count   = 0;
    int unsigned words_sent    = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("path_word_hash regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            hashes.check_hash(out_ch.hash, out_ch.truncated);
    end

    // receiver: random stall modes of random length, long hold-offs on request
    initial begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned stall_mode;
        logic [7:0]  ready_bits;
        hold_left    = 0;
        mode_left    = 0;
        stall_mode   = 0;
        ready_bits   = 8'b1011_0010;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left    = HOLD_TICKS - 1;
                out_ch.ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    0: begin
                        out_ch.ready = 1'b1;
                    end
                    1: begin
                        out_ch.ready = 1'($urandom_range(0, 1));
                    end
                    2: begin
                        out_ch.ready = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        out_ch.ready = ready_bits[0];
                        ready_bits   = {ready_bits[0], ready_bits[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic logic [31:0] any_path_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = 32'd1 << $urandom_range(0, 31);
            1: w = ~(32'd1 << $urandom_range(0, 31));
            2: w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        if (w == 32'd0)
            w = 32'd1;
        return w;
    endfunction

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            in_ch.word  = $urandom;
            in_ch.last  = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic push_word(input logic [31:0] word, input logic last);
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.word  = word;
        in_ch.last  = last;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        hashes.note_word(word, last);
        words_sent++;
    endtask

    // sender bursts: random length, random gaps, some long unbroken runs
    task automatic offer_word(input logic [31:0] word, input logic last);
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push_word(word, last);
    endtask

    task automatic send_path(input int unsigned n_words, input t_path_end ending);
        for (int unsigned i = 0; i < n_words; i++)
            offer_word(any_path_word(), ending == END_LAST && i == n_words - 1);
        if (ending != END_LAST || n_words == 0)
            offer_word(32'd0, ending == END_ZERO_LAST);
    endtask

    task automatic wait_for_hashes();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (hashes.pending_hashes.size() != 0)
            @(negedge i_clk);
        burst_left = 0;
    endtask

    initial begin
        int unsigned path_index;
        int unsigned pick;
        int unsigned n_words;
        t_path_end   ending;

        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.word  = 32'd0;
        in_ch.last  = 1'b0;
        repeat (RESET_TICKS) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty paths, zero word with and without last
        push_word(32'd0, 1'b0);
        push_word(32'd0, 1'b1);
        // single extreme words
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0001, 1'b1);
        // zero word closing a path, then mixed paths ended by last or a zero word
        push_word(32'h0000_0001, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'hA5A5_A5A5, 1'b1);
        push_word(32'h7FFF_FFFF, 1'b1);
        push_word(32'hFFFF_FFFE, 1'b0);
        push_word(32'd0, 1'b1);
        push_word(32'h5A5A_5A5A, 1'b0);
        push_word(32'h0000_8000, 1'b0);
        push_word(32'hC0DE_0001, 1'b1);
        wait_for_hashes();

        path_index = 0;
        while (words_sent < WORD_BUDGET) begin
            if (path_index == 8 || path_index == 50)
                hold_requests++;
            if (path_index == 30 || path_index == 70)
                wait_for_hashes();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                n_words = 0;
            else if (pick < 75)
                n_words = $urandom_range(1, 6);
            else if (pick < 88)
                n_words = $urandom_range(7, 20);
            else
                n_words = $urandom_range(pwh_pkg::MAX_WORDS_DEF - 4,
                                         pwh_pkg::MAX_WORDS_DEF + 6);
            case ($urandom_range(0, 2))
                0: ending = END_LAST;
                1: ending = END_ZERO;
                default: ending = END_ZERO_LAST;
            endcase
            send_path(n_words, ending);
            path_index++;
        end

        wait_for_hashes();
        repeat (TAIL_TICKS) @(posedge i_clk);
        if (hashes.all_clear())
            $display("path_word_hash regression: pass");
        else
            $display("path_word_hash regression: fail");
        $finish;
    end
endmodule
